>>> rtl/etu_pkg.sv
// Package for the triangle eikonal update: widths, stage records and overflow helpers.
package etu_pkg;

    localparam int DW        = 32;              // signed datapath width
    localparam int FB        = 16;              // fraction bits
    localparam int TW        = DW - 1;          // width of a time value
    localparam int PW        = 2 * DW;          // full product width
    localparam int SQ_IN     = DW + FB;         // radicand width, d shifted by FB
    localparam int SQ_STEPS  = SQ_IN / 2;       // root bits, one per sqrt stage
    localparam int SQ_REM    = SQ_STEPS + 2;    // partial remainder width
    localparam int DIV_STEPS = DW + FB;         // quotient bits, one per divide stage
    localparam int IN_W      = 256;
    localparam int OUT_W     = 32;

    typedef struct packed {
        logic                 ok;
        logic [TW-1:0]        w;
        logic signed [DW-1:0] ra;
        logic signed [DW-1:0] rb;
        logic [TW-1:0]        base;
        logic signed [DW-1:0] a2;
        logic signed [DW-1:0] qb;
    } carry_t;

    // True when a full product, already shifted down, fits the signed datapath.
    function automatic logic fit_p(input logic signed [PW-1:0] x);
        fit_p = (&x[PW-1:DW-1]) | ~(|x[PW-1:DW-1]);
    endfunction

    // True when a sum carried two extra bits fits the signed datapath.
    function automatic logic fit_s(input logic signed [DW+1:0] x);
        fit_s = (&x[DW+1:DW-1]) | ~(|x[DW+1:DW-1]);
    endfunction

endpackage

>>> rtl/eikonal_triangle_update.sv
// Top level of the pipelined triangle update of a fast marching eikonal solver.
// The block takes one stencil per beat on the slave channel and returns one
// result beat per stencil on the master channel, in order.
// Slave channel: s_tvalid, s_tready, s_tdata carries the two known arrival times
// (unsigned Q15.16) and the six stencil coefficients (signed Q16.16).
// Master channel: m_tvalid, m_tready, m_tdata carries the new arrival time and
// m_tuser says whether it is a valid solution inside the triangle.
// Throughput is one beat per cycle while the receiver does not stall; the
// pipeline depth comes from the square root (one root bit per stage, 24 stages)
// and the divider (one quotient bit per stage, 48 stages), plus ten stages of
// multiplies and checks.
// The whole pipeline moves on one enable that is high while the output register
// is empty or being taken, so a stalled receiver freezes every stage in place
// and no beat is lost or repeated; s_tready drops only while the output holds
// an untaken result.
// Reset clears every valid bit; data registers are not reset.
module eikonal_triangle_update
    import etu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // From bit 0: time_first(31), time_second(31), quad_coef_first(32),
    // quad_coef_second(32), const_coef_first(32), const_coef_second(32),
    // ratio_first_over_second(32), ratio_second_over_first(32), two zero bits.
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // From bit 0: new_time(31), one zero bit.
    output logic [OUT_W-1:0] m_tdata,
    // Bit 0: solved.
    output logic             m_tuser
);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Input unpacking and coefficient selection by the sign of the difference.
    logic [TW-1:0]        t1, t2;
    logic signed [DW-1:0] q1, q2, c1, c2, r12, r21;
    logic signed [DW:0]   u;
    assign t1  = s_tdata[30:0];
    assign t2  = s_tdata[61:31];
    assign q1  = $signed(s_tdata[93:62]);
    assign q2  = $signed(s_tdata[125:94]);
    assign c1  = $signed(s_tdata[157:126]);
    assign c2  = $signed(s_tdata[189:158]);
    assign r12 = $signed(s_tdata[221:190]);
    assign r21 = $signed(s_tdata[253:222]);
    assign u   = $signed({2'b00, t2}) - $signed({2'b00, t1});

    // Stage 1: selected operands.
    logic                 v1_reg;
    carry_t               k1_reg, k1_next;
    logic signed [DW-1:0] qa1_reg, qa1_next, cc1_reg, cc1_next;

    always_comb
    begin
        k1_next    = '0;
        k1_next.ok = 1'b1;
        if (!u[DW])
        begin
            k1_next.w    = u[TW-1:0];
            k1_next.ra   = r21;
            k1_next.rb   = r12;
            k1_next.base = t1;
            qa1_next     = q2;
            cc1_next     = c2;
        end
        else
        begin
            k1_next.w    = t1 - t2;
            k1_next.ra   = r12;
            k1_next.rb   = r21;
            k1_next.base = t2;
            qa1_next     = q1;
            cc1_next     = c1;
        end
    end

    // Stage 2: qb and w squared as full products, doubled leading coefficient.
    logic                 v2_reg;
    carry_t               k2_reg, k2_next;
    logic signed [PW-1:0] pqb2_reg, pww2_reg;
    logic signed [DW-1:0] cc2_reg;
    logic signed [DW+1:0] a2w;

    assign a2w = $signed({{2{qa1_reg[DW-1]}}, qa1_reg}) <<< 1;
    always_comb
    begin
        k2_next    = k1_reg;
        k2_next.a2 = a2w[DW-1:0];
        k2_next.ok = k1_reg.ok && (qa1_reg != '0) && fit_s(a2w);
    end

    // Stage 3: scale products, qc and its double.
    logic                 v3_reg;
    carry_t               k3_reg, k3_next;
    logic signed [DW-1:0] c2_3_reg;
    logic signed [PW-1:0] qbs, wws;
    logic signed [DW+1:0] qcw, c2w;

    assign qbs = pqb2_reg >>> FB;
    assign wws = pww2_reg >>> FB;
    assign qcw = $signed({{2{wws[DW-1]}}, wws[DW-1:0]})
               + $signed({{2{cc2_reg[DW-1]}}, cc2_reg});
    assign c2w = qcw <<< 1;
    always_comb
    begin
        k3_next    = k2_reg;
        k3_next.qb = qbs[DW-1:0];
        k3_next.ok = k2_reg.ok && fit_p(qbs) && fit_p(wws) && fit_s(qcw) && fit_s(c2w);
    end

    // Stage 4: products for the discriminant.
    logic                 v4_reg;
    carry_t               k4_reg;
    logic signed [PW-1:0] pp4_reg, psq4_reg;

    // Stage 5: discriminant.
    logic                 v5_reg;
    carry_t               k5_reg, k5_next;
    logic [TW-1:0]        d5_reg;
    logic signed [PW-1:0] ps, sqs;
    logic signed [DW+1:0] dw;

    assign ps  = pp4_reg >>> FB;
    assign sqs = psq4_reg >>> FB;
    assign dw  = $signed({{2{sqs[DW-1]}}, sqs[DW-1:0]})
               - $signed({{2{ps[DW-1]}}, ps[DW-1:0]});
    always_comb
    begin
        k5_next    = k4_reg;
        k5_next.ok = k4_reg.ok && fit_p(ps) && fit_p(sqs)
                     && (ps[DW-1:0] != {1'b1, {(DW-1){1'b0}}})
                     && (k4_reg.qb != {1'b1, {(DW-1){1'b0}}})
                     && fit_s(dw) && !dw[DW+1];
    end

    // Square root pipeline, one root bit per stage.
    logic                 sv_reg  [1:SQ_STEPS];
    carry_t               sk_reg  [1:SQ_STEPS];
    logic [SQ_REM-1:0]    srem_reg[1:SQ_STEPS];
    logic [SQ_STEPS-1:0]  sroot_reg[1:SQ_STEPS];
    logic [SQ_IN-1:0]     sx_reg  [1:SQ_STEPS];

    genvar gi;
    generate
        for (gi = 0; gi < SQ_STEPS; gi++)
        begin : g_sqrt
            logic                v_in;
            carry_t              k_in;
            logic [SQ_REM-1:0]   rem_in;
            logic [SQ_STEPS-1:0] root_in;
            logic [SQ_IN-1:0]    x_in;
            logic [SQ_REM+1:0]   remw, trial;
            logic                take;
            if (gi == 0)
            begin : g_head
                // The first stage starts from the discriminant shifted up by FB.
                assign v_in    = v5_reg;
                assign k_in    = k5_reg;
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = {1'b0, d5_reg, {FB{1'b0}}};
            end
            else
            begin : g_link
                assign v_in    = sv_reg[gi];
                assign k_in    = sk_reg[gi];
                assign rem_in  = srem_reg[gi];
                assign root_in = sroot_reg[gi];
                assign x_in    = sx_reg[gi];
            end
            assign remw  = {rem_in, x_in[SQ_IN-1 -: 2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign take  = remw >= trial;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_reg[gi+1] <= 1'b0;
                end
                else if (en)
                begin
                    sv_reg[gi+1] <= v_in;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sk_reg[gi+1]    <= k_in;
                    srem_reg[gi+1]  <= take ? SQ_REM'(remw - trial) : remw[SQ_REM-1:0];
                    sroot_reg[gi+1] <= {root_in[SQ_STEPS-2:0], take};
                    sx_reg[gi+1]    <= x_in << 2;
                end
            end
        end
    endgenerate

    // Stage 6: numerator of the root and operand magnitudes for the divider.
    logic                 v6_reg;
    carry_t               k6_reg, k6_next;
    logic [DW-1:0]        mn6_reg, md6_reg, mn6_next, md6_next;
    logic                 neg6_reg;
    logic signed [DW+1:0] numw;

    assign numw = $signed({{(DW+2-SQ_STEPS){1'b0}}, sroot_reg[SQ_STEPS]})
                - $signed({{2{sk_reg[SQ_STEPS].qb[DW-1]}}, sk_reg[SQ_STEPS].qb});
    assign mn6_next = numw[DW+1] ? DW'(-numw) : numw[DW-1:0];
    assign md6_next = sk_reg[SQ_STEPS].a2[DW-1] ? DW'(-sk_reg[SQ_STEPS].a2)
                                                 : sk_reg[SQ_STEPS].a2;
    always_comb
    begin
        k6_next    = sk_reg[SQ_STEPS];
        k6_next.ok = sk_reg[SQ_STEPS].ok && fit_s(numw);
    end

    // Divider pipeline, one quotient bit per stage.
    logic                 dv_reg [1:DIV_STEPS];
    carry_t               dk_reg [1:DIV_STEPS];
    logic [DW-1:0]        drem_reg[1:DIV_STEPS];
    logic [DW-1:0]        dden_reg[1:DIV_STEPS];
    logic [DIV_STEPS-1:0] dq_reg [1:DIV_STEPS];
    logic                 dneg_reg[1:DIV_STEPS];

    generate
        for (gi = 0; gi < DIV_STEPS; gi++)
        begin : g_div
            logic                 v_in;
            carry_t               k_in;
            logic [DW-1:0]        rem_in;
            logic [DW-1:0]        den_in;
            logic [DIV_STEPS-1:0] q_in;
            logic                 neg_in;
            logic [DW:0]          remw;
            logic                 take;
            if (gi == 0)
            begin : g_head
                // The dividend is the numerator magnitude shifted up by FB.
                assign v_in   = v6_reg;
                assign k_in   = k6_reg;
                assign rem_in = '0;
                assign den_in = md6_reg;
                assign q_in   = {mn6_reg, {FB{1'b0}}};
                assign neg_in = neg6_reg;
            end
            else
            begin : g_link
                assign v_in   = dv_reg[gi];
                assign k_in   = dk_reg[gi];
                assign rem_in = drem_reg[gi];
                assign den_in = dden_reg[gi];
                assign q_in   = dq_reg[gi];
                assign neg_in = dneg_reg[gi];
            end
            assign remw = {rem_in, q_in[DIV_STEPS-1]};
            assign take = remw >= {1'b0, den_in};
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[gi+1] <= 1'b0;
                end
                else if (en)
                begin
                    dv_reg[gi+1] <= v_in;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dk_reg[gi+1]   <= k_in;
                    drem_reg[gi+1] <= take ? DW'(remw - {1'b0, den_in})
                                           : remw[DW-1:0];
                    dden_reg[gi+1] <= den_in;
                    dq_reg[gi+1]   <= {q_in[DIV_STEPS-2:0], take};
                    dneg_reg[gi+1] <= neg_in;
                end
            end
        end
    endgenerate

    // Stage 7: signed quotient rounded toward minus infinity.
    logic                 v7_reg;
    carry_t               k7_reg, k7_next;
    logic signed [DW-1:0] t7_reg, t7_next;
    logic [DIV_STEPS:0]   magq;
    logic                 qneg;

    assign qneg = dneg_reg[DIV_STEPS];
    assign magq = {1'b0, dq_reg[DIV_STEPS]}
                + {{DIV_STEPS{1'b0}}, qneg && (drem_reg[DIV_STEPS] != '0)};
    assign t7_next = qneg ? $signed(DW'(-magq[DW-1:0])) : $signed(magq[DW-1:0]);
    always_comb
    begin
        k7_next    = dk_reg[DIV_STEPS];
        k7_next.ok = dk_reg[DIV_STEPS].ok &&
                     (qneg ? (magq <= {{(DIV_STEPS-DW+1){1'b0}}, 1'b1, {(DW-1){1'b0}}})
                           : (magq <  {{(DIV_STEPS-DW+1){1'b0}}, 1'b1, {(DW-1){1'b0}}}));
    end

    // Stage 8: first triangle product, t minus w and the sum.
    logic                 v8_reg;
    carry_t               k8_reg, k8_next;
    logic signed [PW-1:0] pa8_reg;
    logic signed [DW-1:0] tw8_reg;
    logic [TW-1:0]        sum8_reg;
    logic signed [DW+1:0] tww, sumw;

    assign tww  = $signed({{2{t7_reg[DW-1]}}, t7_reg}) - $signed({3'b000, k7_reg.w});
    assign sumw = $signed({3'b000, k7_reg.base}) + $signed({{2{t7_reg[DW-1]}}, t7_reg});
    always_comb
    begin
        k8_next    = k7_reg;
        k8_next.ok = k7_reg.ok && fit_s(tww) && !sumw[DW+1] && !sumw[DW] && !sumw[DW-1]
                     && !k7_reg.w[TW-1];
    end

    // Stage 9: first triangle test and the second product.
    logic                 v9_reg;
    carry_t               k9_reg, k9_next;
    logic signed [PW-1:0] pb9_reg;
    logic [TW-1:0]        sum9_reg;
    logic signed [PW-1:0] pas;
    logic signed [DW+1:0] nw2;

    assign pas = pa8_reg >>> FB;
    assign nw2 = -($signed({3'b000, k8_reg.w}) <<< 1);
    always_comb
    begin
        k9_next    = k8_reg;
        k9_next.ok = k8_reg.ok && fit_p(pas)
                     && (nw2 >= $signed({{2{pas[DW-1]}}, pas[DW-1:0]}));
    end

    // Output register: second triangle test.
    logic signed [PW-1:0] pbs;
    logic signed [DW+1:0] w2;
    logic                 okf;
    logic [TW-1:0]        new_time_reg;
    logic                 solved_reg;
    logic                 out_v_reg;

    assign pbs = pb9_reg >>> FB;
    assign w2  = $signed({3'b000, k9_reg.w}) <<< 1;
    assign okf = k9_reg.ok && fit_p(pbs) && ($signed({{2{pbs[DW-1]}}, pbs[DW-1:0]}) <= w2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            v8_reg    <= 1'b0;
            v9_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= sv_reg[SQ_STEPS];
            v7_reg    <= dv_reg[DIV_STEPS];
            v8_reg    <= v7_reg;
            v9_reg    <= v8_reg;
            out_v_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg       <= k1_next;
            qa1_reg      <= qa1_next;
            cc1_reg      <= cc1_next;
            k2_reg       <= k2_next;
            pqb2_reg     <= $signed({1'b0, k1_reg.w}) * k1_reg.ra;
            pww2_reg     <= $signed({1'b0, k1_reg.w}) * $signed({1'b0, k1_reg.w});
            cc2_reg      <= cc1_reg;
            k3_reg       <= k3_next;
            c2_3_reg     <= c2w[DW-1:0];
            k4_reg       <= k3_reg;
            pp4_reg      <= k3_reg.a2 * c2_3_reg;
            psq4_reg     <= k3_reg.qb * k3_reg.qb;
            k5_reg       <= k5_next;
            d5_reg       <= dw[TW-1:0];
            k6_reg       <= k6_next;
            mn6_reg      <= mn6_next;
            md6_reg      <= md6_next;
            neg6_reg     <= numw[DW+1] ^ sk_reg[SQ_STEPS].a2[DW-1];
            k7_reg       <= k7_next;
            t7_reg       <= t7_next;
            k8_reg       <= k8_next;
            pa8_reg      <= k7_reg.ra * t7_reg;
            tw8_reg      <= tww[DW-1:0];
            sum8_reg     <= sumw[TW-1:0];
            k9_reg       <= k9_next;
            pb9_reg      <= k8_reg.rb * tw8_reg;
            sum9_reg     <= sum8_reg;
            new_time_reg <= okf ? sum9_reg : '0;
            solved_reg   <= okf;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(OUT_W-TW){1'b0}}, new_time_reg};
    assign m_tuser  = solved_reg;

`ifndef SYNTHESIS
    // An unsolved result always carries a zero time.
    a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("unsolved result with nonzero time");

    // The input side only stalls while an untaken result sits in the output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // A held result does not change while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("output changed during stall");
`endif

endmodule
